FILE: sv/multi_mode_slot_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-mode slot scheduler
// Shorthand for the concurrent checks used by the scheduler checker.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_SLOT_SCHEDULER_MACROS_SVH
`define MULTI_MODE_SLOT_SCHEDULER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MMSS_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MMSS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MMSS_ASSERT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mmss_pkg.sv
// ----------------------------------------------------------------------------
// Slot scheduler package
// Shared constants, codes, record types and helpers of the slot scheduler.
// ----------------------------------------------------------------------------
package mmss_pkg;

  localparam int NUM_SLOTS = 5;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  typedef logic [SLOT_W-1:0] slot_t;

  localparam slot_t FIRST_SLOT = slot_t'(1);
  localparam slot_t LAST_SLOT  = slot_t'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    OP_YIELD     = 2'd0,
    OP_EXIT      = 2'd1,
    OP_SET_PRIO  = 2'd2,
    OP_SET_SHARE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_RR       = 2'd0,
    MODE_STRICT   = 2'd1,
    MODE_TOP_PRIO = 2'd2,
    MODE_SHARE    = 2'd3
  } mode_t;

  typedef struct packed {
    logic       run;
    logic [7:0] prio;
    logic [7:0] share;
    logic [7:0] left;
  } slot_rec_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

  function automatic slot_t slot_wrap_inc(input slot_t s);
    return (s == LAST_SLOT) ? '0 : s + slot_t'(1);
  endfunction

  function automatic logic [2:0] slot_field(input slot_t s);
    logic [SLOT_W+2:0] ext;
    ext = {3'b000, s};
    return ext[2:0];
  endfunction

endpackage

FILE: sv/mmss_slot_file.sv
// ----------------------------------------------------------------------------
// Slot record file
// Per-slot runnable flag, priority, share and share count, one read port.
// ----------------------------------------------------------------------------
module mmss_slot_file
  import mmss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  slot_t     rd_idx,
  output slot_rec_t rd_rec,
  input  logic      wr_en,
  input  slot_t     wr_idx,
  input  slot_rec_t wr_rec
);

  slot_rec_t slots [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slots[i].run   <= (i != 0);
        slots[i].prio  <= (i == 0) ? 8'd0 : ((i == NUM_SLOTS - 1) ? 8'd2 : 8'd1);
        slots[i].share <= 8'(i);
        slots[i].left  <= 8'(i);
      end
    end else if (wr_en) begin
      slots[wr_idx] <= wr_rec;
    end
  end

  assign rd_rec = slots[rd_idx];

endmodule

FILE: sv/mmss_cmp.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// Byte magnitude and equality compare used by the scan steps.
// ----------------------------------------------------------------------------
module mmss_cmp
  import mmss_pkg::*;
(
  input  logic [7:0] a,
  input  logic [7:0] b,
  output cmp_res_t   res
);

  assign res.gt = (a > b);
  assign res.eq = (a == b);

endmodule

FILE: sv/mmss_seq.sv
// ----------------------------------------------------------------------------
// Scheduling sequencer
// Applies an event to the current slot, then, unless share mode keeps it,
// scans the slots one per cycle via the compare unit and registers a result.
// ----------------------------------------------------------------------------
module mmss_seq
  import mmss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mode_t      mode,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [1:0] s_op,
  input  logic [7:0] s_value,
  output logic       m_valid,
  input  logic       m_ready,
  output logic [2:0] m_slot,
  output logic       m_idle,
  output slot_t      rd_idx,
  input  slot_rec_t  rd_rec,
  output logic       wr_en,
  output slot_t      wr_idx,
  output slot_rec_t  wr_rec,
  output logic [7:0] cmp_a,
  output logic [7:0] cmp_b,
  input  cmp_res_t   cmp_res
);

  typedef enum logic [2:0] {
    S_WAIT,
    S_APPLY,
    S_MAX,
    S_RELOAD,
    S_FIND,
    S_CYC,
    S_DONE
  } state_t;

  state_t     state;
  slot_t      cur;
  slot_t      idx;
  logic [7:0] acc;
  logic       found;
  op_t        op_q;
  logic [7:0] val_q;
  slot_t      res_slot;
  logic       res_idle;

  slot_rec_t  apply_rec;
  slot_rec_t  reload_rec;
  logic       elig;
  logic       take;
  logic [7:0] acc_next;
  logic       found_next;
  logic       find_hit;
  logic       cyc_hit;

  always_comb begin
    apply_rec = rd_rec;
    case (op_q)
      OP_EXIT:      apply_rec.run = 1'b0;
      OP_SET_PRIO:  apply_rec.prio = val_q;
      OP_SET_SHARE: begin
        apply_rec.share = val_q;
        apply_rec.left  = val_q;
      end
      default:      apply_rec = rd_rec;
    endcase
    if (mode == MODE_SHARE && apply_rec.left != 8'd0) begin
      apply_rec.left = apply_rec.left - 8'd1;
    end

    reload_rec      = rd_rec;
    reload_rec.left = rd_rec.share;

    rd_idx = (state == S_APPLY) ? cur : idx;
    wr_idx = rd_idx;
    wr_en  = (state == S_APPLY) || (state == S_RELOAD && rd_rec.run);
    wr_rec = (state == S_APPLY) ? apply_rec : reload_rec;

    cmp_a = ((state == S_MAX && mode == MODE_TOP_PRIO) || state == S_CYC) ?
            rd_rec.prio : rd_rec.share;
    cmp_b = acc;

    elig = rd_rec.run &&
           (rd_rec.left > 8'd1 || (rd_rec.share == 8'd1 && rd_rec.left == 8'd1));
    take = (state == S_RELOAD || mode == MODE_TOP_PRIO) ? rd_rec.run : elig;
    acc_next   = (take && cmp_res.gt) ? cmp_a : acc;
    found_next = found | take;

    find_hit = rd_rec.run && (mode == MODE_STRICT || cmp_res.eq);
    cyc_hit  = rd_rec.run && (mode == MODE_RR || cmp_res.eq);
  end

  assign s_ready = (state == S_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_WAIT;
      cur     <= '0;
      m_valid <= 1'b0;
    end else begin
      if (m_valid && m_ready && state != S_DONE) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_WAIT: begin
          if (s_valid) begin
            op_q  <= op_t'(s_op);
            val_q <= s_value;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          acc   <= 8'd0;
          found <= 1'b0;
          idx   <= FIRST_SLOT;
          unique case (mode)
            MODE_RR: begin
              idx   <= slot_wrap_inc(cur);
              state <= S_CYC;
            end
            MODE_STRICT:   state <= S_FIND;
            MODE_TOP_PRIO: state <= S_MAX;
            MODE_SHARE: begin
              if (apply_rec.run && apply_rec.left != 8'd0) begin
                res_slot <= cur;
                res_idle <= 1'b0;
                state    <= S_DONE;
              end else begin
                state <= S_MAX;
              end
            end
            default: state <= S_MAX;
          endcase
        end
        S_MAX: begin
          acc   <= acc_next;
          found <= found_next;
          if (idx == LAST_SLOT) begin
            if (mode == MODE_TOP_PRIO) begin
              idx   <= slot_wrap_inc(cur);
              state <= S_CYC;
            end else begin
              idx   <= FIRST_SLOT;
              state <= found_next ? S_FIND : S_RELOAD;
            end
          end else begin
            idx <= idx + slot_t'(1);
          end
        end
        S_RELOAD: begin
          acc   <= acc_next;
          found <= found_next;
          if (idx == LAST_SLOT) begin
            idx <= FIRST_SLOT;
            if (found_next) begin
              state <= S_FIND;
            end else begin
              res_idle <= 1'b1;
              state    <= S_DONE;
            end
          end else begin
            idx <= idx + slot_t'(1);
          end
        end
        S_FIND: begin
          if (find_hit) begin
            res_slot <= idx;
            res_idle <= 1'b0;
            state    <= S_DONE;
          end else if (idx == LAST_SLOT) begin
            res_idle <= 1'b1;
            state    <= S_DONE;
          end else begin
            idx <= idx + slot_t'(1);
          end
        end
        S_CYC: begin
          if (cyc_hit) begin
            res_slot <= idx;
            res_idle <= 1'b0;
            state    <= S_DONE;
          end else if (idx == cur) begin
            res_idle <= 1'b1;
            state    <= S_DONE;
          end else begin
            idx <= slot_wrap_inc(idx);
          end
        end
        S_DONE: begin
          if (!m_valid || m_ready) begin
            m_valid <= 1'b1;
            m_slot  <= slot_field(res_idle ? cur : res_slot);
            m_idle  <= res_idle;
            if (!res_idle) begin
              cur <= res_slot;
            end
            state <= S_WAIT;
          end
        end
        default: state <= S_WAIT;
      endcase
    end
  end

endmodule

FILE: sv/multi_mode_slot_scheduler.sv
// An event is applied to the current slot, and a scan may follow before the result is registered.
// The result also waits while the previous result is still held by the receiver.
// The sequencer reads one slot record per cycle through the single read port.
// A new event is taken in the cycle after the result is registered.
// Synchronous reset restores the slot records, current slot 0 and mode 3.
// ----------------------------------------------------------------------------
// Multi-mode slot scheduler
// Chooses the next task slot per event under one of four selectable policies.
// ----------------------------------------------------------------------------
module multi_mode_slot_scheduler
  import mmss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] value
  input  logic [1:0] s_tuser,   // [1:0] op
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [2:0] next_slot, [7:3] zero
  output logic [0:0] m_tuser,   // [0] idle
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  mode_t      mode;
  slot_t      rd_idx;
  slot_rec_t  rd_rec;
  logic       wr_en;
  slot_t      wr_idx;
  slot_rec_t  wr_rec;
  logic [7:0] cmp_a;
  logic [7:0] cmp_b;
  cmp_res_t   cmp_res;
  logic [2:0] m_slot;
  logic       m_idle;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SHARE;
    end else if (cfg_valid && cfg_ready) begin
      mode <= mode_t'(cfg_data);
    end
  end

  mmss_slot_file u_slot_file (
    .clk    (clk),
    .rst    (rst),
    .rd_idx (rd_idx),
    .rd_rec (rd_rec),
    .wr_en  (wr_en),
    .wr_idx (wr_idx),
    .wr_rec (wr_rec)
  );

  mmss_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  mmss_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .mode    (mode),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_op    (s_tuser),
    .s_value (s_tdata),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_slot  (m_slot),
    .m_idle  (m_idle),
    .rd_idx  (rd_idx),
    .rd_rec  (rd_rec),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_rec  (wr_rec),
    .cmp_a   (cmp_a),
    .cmp_b   (cmp_b),
    .cmp_res (cmp_res)
  );

  assign m_tdata = {5'b00000, m_slot};
  assign m_tuser = m_idle;

endmodule

FILE: sv/mmss_checker.sv
// ----------------------------------------------------------------------------
// Slot scheduler checker
// Port-level checks of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "multi_mode_slot_scheduler_macros.svh"

module mmss_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [0:0] m_tuser
);

  `MMSS_ASSERT_ALWAYS(a_reset_state, rst, s_tready && !m_tvalid, "Bad state after reset.")
  `MMSS_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "Event taken while busy.")
  `MMSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result changed.")
  `MMSS_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[7:3] == 5'b00000, "Result padding not zero.")

endmodule

bind multi_mode_slot_scheduler mmss_checker u_mmss_checker (.*);
